>>> hw/rtl/inorm_pkg.sv
// Package for the instance normalisation block.
// Holds the controller state type, command and status structs and register indexes.
// Used by inorm_ctrl, inorm_dp and instance_normalization.
package inorm_pkg;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_NN,
    S_MDIV,
    S_MDIV_WAIT,
    S_MUL,
    S_NUM,
    S_VDIV,
    S_VDIV_WAIT,
    S_DEN,
    S_RDIV,
    S_RDIV_WAIT,
    S_SQRT,
    S_FIN,
    S_PLO,
    S_PHI,
    S_PSUM,
    S_TVAL,
    S_TGAIN,
    S_OUT
  } inorm_state_t;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_RECIP
  } inorm_div_sel_t;

  // Configuration register indexes.
  localparam logic [0:0] REG_EPSILON = 1'b0;
  localparam logic [0:0] REG_AFFINE  = 1'b1;
  localparam logic [15:0] EPSILON_RESET = 16'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic           acc;
    logic           load_norm;
    logic           sq;
    logic           nn;
    logic           div_start;
    inorm_div_sel_t div_sel;
    logic           mean_wr;
    logic           mul_step;
    logic           num;
    logic           var_wr;
    logic           den;
    logic           sqrt_init;
    logic           sqrt_step;
    logic           fin;
    logic           plo;
    logic           phi;
    logic           psum;
    logic           tval;
    logic           tgain;
    logic           out_wr;
  } inorm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic mul_last;
    logic sqrt_last;
    logic affine;
  } inorm_status_t;

endpackage

>>> hw/rtl/inorm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; instantiated by inorm_dp.
module inorm_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);

  localparam int CNT_W = $clog2(W);

  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [W-1:0]     den;
  logic [W:0]       trial;
  logic [W:0]       diff;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {remainder, quotient[W-1]};
    diff  = trial - {1'b0, den};
  end

  // Control: run for one cycle per quotient bit and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      den       <= divisor;
    end else if (run) begin
      if (!diff[W]) begin
        remainder <= diff[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= trial[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/inorm_dp.sv
// Datapath of the instance normalisation block: accumulators, statistics units, output stage.
// Depends on inorm_pkg and inorm_div.
module inorm_dp
  import inorm_pkg::*;
#(
  parameter int MAX_PLANE = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  inorm_cmd_t         cmd,
  output inorm_status_t      status,
  input  logic [15:0]        epsilon,
  input  logic               affine_mode,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] gain,
  input  logic signed [15:0] bias,
  input  logic               last,
  output logic signed [15:0] normalized,
  output logic               last_out,
  output logic               done
);

  localparam int CW = $clog2(MAX_PLANE + 1);
  localparam int NW = 2 * CW;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PLANE);

  // Statistics state.
  logic signed [32:0] sum_q;
  logic [47:0]        sumsq_q;
  logic [CW-1:0]      count_q;
  logic signed [23:0] mean_q;
  logic [31:0]        inv_q;

  // Intermediate statistics registers.
  logic [CW-1:0]      neff;
  logic [32:0]        mag;
  logic signed [42:0] mnum;
  logic [63:0]        magsq_q;
  logic               mnum_neg;
  logic [41:0]        mnum_mag;
  logic [2*CW-1:0]    nn_q;
  logic [63:0]        lhs_q;
  logic [63:0]        mcand_q;
  logic [CW-1:0]      mplier_q;
  logic [63:0]        num_q;
  logic [63:0]        var_q;
  logic [63:0]        den_q;
  logic [63:0]        den_sum;
  logic [63:0]        v_q;
  logic [63:0]        r_q;
  logic [63:0]        bit_q;
  logic [63:0]        rb;
  logic [4:0]         iter;
  logic signed [31:0] xsq;
  logic [23:0]        qadj;

  // Divider port.
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic [63:0] div_quo;
  logic [63:0] div_rem;
  logic        div_done;

  // Normalise pass registers.
  logic signed [25:0] d_q;
  logic signed [15:0] gain_q;
  logic signed [15:0] bias_q;
  logic               last_q;
  logic signed [42:0] plo_q;
  logic signed [42:0] phi_q;
  logic signed [59:0] p_q;
  logic signed [39:0] t_q;
  logic signed [55:0] tg_q;
  logic [59:0]        p_round;
  logic [59:0]        y_plain;
  logic [57:0]        y_aff;
  logic [41:0]        y_sel;

  // Clamp a wide signed value to the 16-bit range.
  function automatic logic [15:0] sat16(input logic [41:0] v);
    logic [15:0] r;
    if (!v[41] && (|v[40:15])) begin
      r = 16'h7FFF;
    end else if (v[41] && !(&v[40:15])) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Combinational helpers.
  always_comb begin
    neff     = (count_q == '0) ? CW'(1) : count_q;
    mag      = sum_q[32] ? -sum_q : sum_q;
    mnum     = {{1{sum_q[32]}}, sum_q, 9'b0} + {{(43 - CW){1'b0}}, neff};
    xsq      = 32'(sample) * 32'(sample);
    rb       = r_q + bit_q;
    den_sum  = var_q + 64'(epsilon);
    qadj     = div_quo[23:0] + 24'(div_rem != '0);
    p_round  = p_q + (60'd1 << 19);
    y_plain  = p_q + (60'd1 << 27);
    y_aff    = {{2{tg_q[55]}}, tg_q} + {{26{bias_q[15]}}, bias_q, 16'b0} + (58'd1 << 15);
    if (affine_mode) begin
      y_sel = y_aff[57:16];
    end else begin
      y_sel = {{10{y_plain[59]}}, y_plain[59:28]};
    end
  end

  // Divider operand selection.
  always_comb begin
    case (cmd.div_sel)
      DIV_MEAN: begin
        div_a = 64'(mnum_mag);
        div_b = 64'({neff, 1'b0});
      end
      DIV_VAR: begin
        div_a = num_q;
        div_b = 64'(nn_q);
      end
      DIV_RECIP: begin
        div_a = 64'd1 << 56;
        div_b = den_q;
      end
      default: begin
        div_a = '0;
        div_b = 64'd1;
      end
    endcase
  end

  inorm_div #(
    .W(64)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_quo),
    .remainder(div_rem),
    .done     (div_done)
  );

  // Status back to the controller.
  always_comb begin
    status.div_done  = div_done;
    status.mul_last  = (iter == 5'(CW - 1));
    status.sqrt_last = (iter == 5'd31);
    status.affine    = affine_mode;
  end

  // Plane state: accumulators, mean and inverse deviation.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      mean_q  <= '0;
      inv_q   <= '0;
    end else begin
      if (cmd.acc && (count_q < COUNT_MAX)) begin
        sum_q   <= sum_q + {{17{sample[15]}}, sample};
        sumsq_q <= sumsq_q + {16'b0, xsq};
        count_q <= count_q + 1'b1;
      end
      if (cmd.mean_wr) begin
        mean_q <= mnum_neg ? -qadj : div_quo[23:0];
      end
      if (cmd.fin) begin
        inv_q   <= r_q[31:0];
        sum_q   <= '0;
        sumsq_q <= '0;
        count_q <= '0;
      end
    end
  end

  // Iteration counter shared by the serial multiplier and the root.
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.sq || cmd.sqrt_init) begin
      iter <= '0;
    end else if (cmd.mul_step || cmd.sqrt_step) begin
      iter <= iter + 1'b1;
    end
  end

  // Statistics intermediates.
  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      magsq_q  <= 64'(mag[31:0]) * 64'(mag[31:0]);
      mnum_neg <= mnum[42];
      mnum_mag <= mnum[42] ? 42'(-mnum) : mnum[41:0];
      lhs_q    <= '0;
      mcand_q  <= {16'b0, sumsq_q};
      mplier_q <= neff;
    end
    if (cmd.nn) begin
      nn_q <= NW'(neff) * NW'(neff);
    end
    if (cmd.mul_step) begin
      if (mplier_q[0]) begin
        lhs_q <= lhs_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    if (cmd.num) begin
      num_q <= (lhs_q >= magsq_q) ? lhs_q - magsq_q : '0;
    end
    if (cmd.var_wr) begin
      var_q <= div_quo;
    end
    if (cmd.den) begin
      den_q <= (den_sum == '0) ? 64'd1 : den_sum;
    end
    if (cmd.sqrt_init) begin
      v_q   <= div_quo;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end
    if (cmd.sqrt_step) begin
      if (v_q >= rb) begin
        v_q <= v_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Normalise pass: centre, scale by the inverse deviation, optional gain and bias.
  always_ff @(posedge clk) begin
    if (cmd.load_norm) begin
      d_q    <= {{2{sample[15]}}, sample, 8'b0} - {{2{mean_q[23]}}, mean_q};
      gain_q <= gain;
      bias_q <= bias;
      last_q <= last;
    end
    if (cmd.plo) begin
      plo_q <= 43'(d_q) * 43'($signed({1'b0, inv_q[15:0]}));
    end
    if (cmd.phi) begin
      phi_q <= 43'(d_q) * 43'($signed({1'b0, inv_q[31:16]}));
    end
    if (cmd.psum) begin
      p_q <= {phi_q[42], phi_q, 16'b0} + {{17{plo_q[42]}}, plo_q};
    end
    if (cmd.tval) begin
      t_q <= p_round[59:20];
    end
    if (cmd.tgain) begin
      tg_q <= 56'(t_q) * 56'(gain_q);
    end
    if (cmd.out_wr) begin
      normalized <= sat16(y_sel);
      last_out   <= last_q;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_wr;
    end
  end

endmodule

>>> hw/rtl/inorm_ctrl.sv
// Controller state machine of the instance normalisation block.
// Depends on inorm_pkg; drives inorm_dp through the command struct.
module inorm_ctrl
  import inorm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          func,
  input  logic          last,
  input  inorm_status_t status,
  output inorm_cmd_t    cmd,
  output logic          busy
);

  inorm_state_t state;
  inorm_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          if (func) begin
            cmd.load_norm = 1'b1;
            state_next    = S_PLO;
          end else begin
            cmd.acc = 1'b1;
            if (last) begin
              state_next = S_SQ;
            end
          end
        end
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_NN;
      end
      S_NN: begin
        cmd.nn     = 1'b1;
        state_next = S_MDIV;
      end
      S_MDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_next    = S_MDIV_WAIT;
      end
      S_MDIV_WAIT: begin
        if (status.div_done) begin
          cmd.mean_wr = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = S_NUM;
        end
      end
      S_NUM: begin
        cmd.num    = 1'b1;
        state_next = S_VDIV;
      end
      S_VDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VAR;
        state_next    = S_VDIV_WAIT;
      end
      S_VDIV_WAIT: begin
        if (status.div_done) begin
          cmd.var_wr = 1'b1;
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        cmd.den    = 1'b1;
        state_next = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RECIP;
        state_next    = S_RDIV_WAIT;
      end
      S_RDIV_WAIT: begin
        if (status.div_done) begin
          cmd.sqrt_init = 1'b1;
          state_next    = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      S_PLO: begin
        cmd.plo    = 1'b1;
        state_next = S_PHI;
      end
      S_PHI: begin
        cmd.phi    = 1'b1;
        state_next = S_PSUM;
      end
      S_PSUM: begin
        cmd.psum   = 1'b1;
        state_next = status.affine ? S_TVAL : S_OUT;
      end
      S_TVAL: begin
        cmd.tval   = 1'b1;
        state_next = S_TGAIN;
      end
      S_TGAIN: begin
        cmd.tgain  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_wr = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/instance_normalization.sv
// Instance normalisation top level. Statistics samples (func 0) transfer one per cycle; the
// last one holds busy through three divisions, a 17-step serial multiply and a 32-step
// square root. A normalise sample (func 1) passes states PLO, PHI, PSUM (then TVAL and TGAIN
// in affine mode) and OUT before its result; a new sample is taken in that result's cycle.
// Synchronous active-high reset clears the statistics, sets epsilon to 7 and affine mode off.
// Depends on inorm_pkg, inorm_ctrl and inorm_dp; the receiver cannot stall results.
module instance_normalization
  import inorm_pkg::*;
#(
  parameter int MAX_PLANE = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] gain,
  input  logic signed [15:0] bias,
  input  logic               last,
  output logic signed [15:0] normalized,
  output logic               last_out,
  output logic               done,
  input  logic               wr_en,
  input  logic [0:0]         wr_index,
  input  logic [15:0]        wr_data
);

  logic [15:0]   epsilon;
  logic          affine_mode;
  inorm_cmd_t    cmd;
  inorm_status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon     <= EPSILON_RESET;
      affine_mode <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_EPSILON: epsilon     <= wr_data;
        REG_AFFINE:  affine_mode <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  inorm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .last  (last),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  inorm_dp #(
    .MAX_PLANE(MAX_PLANE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .epsilon    (epsilon),
    .affine_mode(affine_mode),
    .sample     (sample),
    .gain       (gain),
    .bias       (bias),
    .last       (last),
    .normalized (normalized),
    .last_out   (last_out),
    .done       (done)
  );

  // A result only follows work done while busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // A statistics transfer never produces a result.
  a_stat_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !func) |=> !done)
    else $error("statistics sample produced a result");

  // A normalise transfer always starts work.
  a_norm_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func) |=> busy)
    else $error("normalise sample did not start work");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the instance normalisation block.
// It predicts every normalised sample from its own model of the statistics and compares it
// with each result strobe. Depends on inorm_pkg and instance_normalization.
`timescale 1ns / 1ps

import inorm_pkg::*;

// Scoreboard: it keeps the plane statistics and the queue of predicted normalised samples.
class norm_scoreboard;
  typedef struct {
    logic signed [15:0] value;
    logic               last_flag;
  } norm_result_t;

  norm_result_t pending[$];
  logic [15:0]  eps;
  logic         affine;
  longint       sum_acc;
  longint unsigned sq_acc;
  longint unsigned count;
  longint       mean_q16;
  longint unsigned inv_dev;
  int           errors;
  int           n_items;
  int           n_results;
  int           n_planes;

  function new();
    eps = EPSILON_RESET;
    affine = 1'b0;
    sum_acc = 0;
    sq_acc = 0;
    count = 0;
    mean_q16 = 0;
    inv_dev = 0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_planes = 0;
  endfunction

  function void set_reg(logic [0:0] idx, logic [15:0] data);
    if (idx == REG_EPSILON) eps = data;
    else affine = data[0];
  endfunction

  function longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Round half up: add half an LSB, then an arithmetic shift floors.
  function longint round_half_up(longint v, int s);
    longint t;
    t = v + (longint'(1) << (s - 1));
    return t >>> s;
  endfunction

  // End of the statistics pass: mean, variance and inverse deviation.
  function void close_plane();
    longint unsigned n, mag, sq, lhs, num, var_q16, den;
    n = (count == 0) ? 1 : count;
    mean_q16 = floor_quot(sum_acc * 512 + longint'(n), longint'(2 * n));
    mag = (sum_acc < 0) ? longint'(-sum_acc) : sum_acc;
    sq = mag * mag;
    lhs = n * sq_acc;
    num = (lhs >= sq) ? lhs - sq : 0;
    var_q16 = num / (n * n);
    den = var_q16 + eps;
    if (den == 0) den = 1;
    inv_dev = int_sqrt((64'd1 << 56) / den);
    sum_acc = 0;
    sq_acc = 0;
    count = 0;
    n_planes++;
  endfunction

  // Notes one accepted sample transfer and queues its prediction, if any.
  function void note_sample(logic f, logic signed [15:0] x, logic signed [15:0] g,
                            logic signed [15:0] b, logic l);
    longint d, p, t, y;
    norm_result_t r;
    n_items++;
    if (!f) begin
      if (count < 65536) begin
        sum_acc = sum_acc + longint'(x);
        sq_acc = sq_acc + longint'(longint'(x) * longint'(x));
        count++;
      end
      if (l) close_plane();
      return;
    end
    d = longint'(x) * 256 - mean_q16;
    p = d * longint'(inv_dev);
    if (affine) begin
      t = round_half_up(p, 20);
      y = round_half_up(t * longint'(g) + longint'(b) * 65536, 16);
    end else begin
      y = round_half_up(p, 28);
    end
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    r.value = y[15:0];
    r.last_flag = l;
    pending.push_back(r);
  endfunction

  // Compares one result transfer with the oldest prediction.
  function void check_result(logic signed [15:0] v, logic l);
    norm_result_t r;
    n_results++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual normalized %0d last_out %0d",
               $time, v, l);
      errors++;
      return;
    end
    r = pending.pop_front();
    if (v !== r.value) begin
      $display("%0t: normalized mismatch: expected %0d actual %0d", $time, r.value, v);
      errors++;
    end
    if (l !== r.last_flag) begin
      $display("%0t: last_out mismatch: expected %0d actual %0d", $time, r.last_flag, l);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               func = 1'b0;
  logic signed [15:0] sample = '0;
  logic signed [15:0] gain = '0;
  logic signed [15:0] bias = '0;
  logic               last = 1'b0;
  logic signed [15:0] normalized;
  logic               last_out;
  logic               done;
  logic               wr_en = 1'b0;
  logic [0:0]         wr_index = REG_EPSILON;
  logic [15:0]        wr_data = '0;

  norm_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int             quiet_cycles = 0;
  logic signed [15:0] plane_buf[$];

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 300;

  always #4 clk = ~clk;

  instance_normalization dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .sample(sample),
    .gain(gain), .bias(bias), .last(last), .normalized(normalized), .last_out(last_out),
    .done(done), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Monitor: sample transfers and result strobes at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_sample(func, sample, gain, bias, last);
      if (done) sb.check_result(normalized, last_out);
    end
  end

  // Watchdog on cycles in which nothing transfers.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
      $display("[instance_normalization] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One sample transfer; start stays high so back-to-back samples need no gap.
  task automatic send_sample(logic f, logic signed [15:0] x, logic signed [15:0] g,
                             logic signed [15:0] b, logic l);
    if (idle_on && $urandom_range(99) < 35) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    func = f;
    sample = x;
    gain = g;
    bias = b;
    last = l;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Waits for every predicted result, then for the statistics stall to run out.
  task automatic drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    drain();
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = data;
    @(negedge clk);
    wr_en = 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic signed [15:0] rand_sample(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(4095))) - 16'sd2048;
      default: return $signed(16'($urandom_range(511))) - 16'sd256;
    endcase
  endfunction

  // A statistics pass over a fresh plane followed, usually, by its normalise pass.
  task automatic run_plane(int len, bit mangle);
    int kind;
    logic signed [15:0] c;
    kind = $urandom_range(3);
    c = 16'($urandom);
    plane_buf.delete();
    for (int i = 0; i < len; i++) plane_buf.push_back(kind == 3 ? c : rand_sample(kind));
    for (int i = 0; i < len; i++) begin
      send_sample(1'b0, plane_buf[i], 16'($urandom), 16'($urandom), i == len - 1);
    end
    if (mangle && $urandom_range(1)) return;
    for (int i = 0; i < len; i++) begin
      send_sample(1'b1, mangle ? rand_sample(0) : plane_buf[i], 16'($urandom), 16'($urandom),
                  mangle ? 1'($urandom_range(1)) : (i == len - 1));
    end
  endtask

  initial begin
    int total;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: normalise before any statistics, then extreme samples and registers.
    idle_on = 1'b0;
    send_sample(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_sample(1'b1, -16'sh8000, -16'sh8000, -16'sh8000, 1'b1);
    send_sample(1'b0, 16'sh7FFF, 16'sh0100, 16'sh0000, 1'b0);
    send_sample(1'b0, -16'sh8000, 16'sh0100, 16'sh0000, 1'b1);
    send_sample(1'b1, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0);
    send_sample(1'b1, -16'sh8000, 16'sh0000, 16'sh0000, 1'b1);
    // A one-sample plane has zero variance, so epsilon alone guards the root.
    send_sample(1'b0, 16'sh0123, 16'sh0000, 16'sh0000, 1'b1);
    send_sample(1'b1, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0);
    send_sample(1'b1, -16'sh8000, 16'sh0000, 16'sh0000, 1'b1);
    write_reg(REG_EPSILON, 16'd0);
    send_sample(1'b0, 16'sh0040, 16'sh0000, 16'sh0000, 1'b1);
    send_sample(1'b1, 16'sh0041, 16'sh0000, 16'sh0000, 1'b1);
    write_reg(REG_AFFINE, 16'd1);
    send_sample(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_sample(1'b1, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
    send_sample(1'b1, 16'sh0000, 16'sh7FFF, -16'sh8000, 1'b1);
    write_reg(REG_EPSILON, 16'hFFFF);
    run_plane(4, 1'b0);
    write_reg(REG_AFFINE, 16'd0);

    // Random phases under several register settings.
    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(REG_EPSILON, 16'd1);
        1: write_reg(REG_AFFINE, 16'd1);
        2: write_reg(REG_EPSILON, 16'hFFFF);
        3: write_reg(REG_EPSILON, 16'($urandom_range(1, 65535)));
        4: write_reg(REG_AFFINE, 16'd0);
        default: write_reg(REG_EPSILON, 16'd7);
      endcase
      while (total < (ph + 1) * 65) begin
        int len;
        idle_on = !(ph == 2);
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
        run_plane(len, $urandom_range(9) == 0);
        total += 2 * len;
        // Hold off until the block has returned everything outstanding.
        if (ph == 3 && total > 220) begin
          start = 1'b0;
          while (sb.pending.size() != 0) @(negedge clk);
        end
      end
    end

    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d sample transfers over %0d planes and %0d results,", sb.n_items,
             sb.n_planes, sb.n_results);
    $display("with epsilon from 0 to 65535, both affine settings and extreme samples.");
    if (sb.errors == 0) begin
      $display("[instance_normalization] OK");
    end else begin
      $display("[instance_normalization] ERROR");
    end
    $finish;
  end
endmodule
